// ===== rtl/tangent_cody_waite_defines.svh =====
// Assertion macros shared by the tangent block.
`ifndef TANGENT_CODY_WAITE_DEFINES_SVH
`define TANGENT_CODY_WAITE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define TCW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define TCW_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/tcw_pkg.sv =====
// Shared types, constants and coefficient helpers for the tangent block.
package tcw_pkg;

	localparam int ANGLE_FRAC_BITS  = 24;
	localparam int RESULT_FRAC_BITS = 32;
	localparam int WORK_FRAC        = 56;
	localparam int ANGLE_W          = 32;
	localparam int TAN_W            = 48;

	// Reduction helpers
	localparam int N_W  = 64 - ANGLE_FRAC_BITS - 32;
	localparam int D1_W = ANGLE_W + 2;
	localparam logic [31:0] RECIP_2PI = 32'hA2F9836E;
	localparam logic [63:0] N_ROUND   = 64'd1 << (ANGLE_FRAC_BITS + 31);
	localparam logic [63:0] C1_NUM    = 64'd3217;
	localparam int C1_SHIFT           = ANGLE_FRAC_BITS - 11;

	// Divider geometry
	localparam int OVF_SHIFT = TAN_W - 1 - RESULT_FRAC_BITS;

	// Pipeline depths
	localparam int RED_LAT = 4;
	localparam int MUL_LAT = 4;
	localparam int DIV_LAT = TAN_W + 3;
	localparam int LAT     = RED_LAT + 5 * MUL_LAT + DIV_LAT;

	localparam logic [63:0] DEC_SCALE = 64'd1000000000000000000;

	typedef logic signed [63:0] work_t;

	typedef struct packed {
		logic neg;
		logic odd;
		logic tiny;
	} tcw_flags_t;

	typedef struct packed {
		logic [TAN_W-1:0] tangent;
		logic             overflow;
	} out_t;

	// Convert an 18-digit decimal fraction to Q.56, rounded to nearest.
	function automatic logic [63:0] dec_to_q(input logic [63:0] d);
		logic [63:0] r;
		logic [63:0] q;
		int i;
		r = d;
		q = '0;
		for (i = 0; i < WORK_FRAC + 1; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= DEC_SCALE) begin
				r = r - DEC_SCALE;
				q[0] = 1'b1;
			end
		end
		return (q + 64'd1) >> 1;
	endfunction

	localparam logic [63:0] C2Q = dec_to_q(64'd4454455103381);
	localparam work_t ONE  = work_t'(64'd1 << WORK_FRAC);
	localparam work_t TINY = work_t'(64'd1 << (WORK_FRAC - 52));
	localparam work_t ZERO = work_t'(64'd0);
	localparam work_t P1 = work_t'(64'd0 - dec_to_q(64'd128283470409574385));
	localparam work_t P2 = work_t'(dec_to_q(64'd2805918241169989));
	localparam work_t P3 = work_t'(64'd0 - dec_to_q(64'd7483634966612));
	localparam work_t Q1 = work_t'(64'd0 - dec_to_q(64'd461616803742904884));
	localparam work_t Q2 = work_t'(dec_to_q(64'd23344852822068728));
	localparam work_t Q3 = work_t'(64'd0 - dec_to_q(64'd208448044220387));

	localparam logic [TAN_W-1:0] POS_LIM = {1'b0, {(TAN_W-1){1'b1}}};
	localparam logic [TAN_W-1:0] NEG_LIM = {1'b1, {(TAN_W-1){1'b0}}};

endpackage

// ===== rtl/tcw_reduce.sv =====
// Cody-Waite reduction of the angle magnitude by the nearest multiple of pi/2.
module tcw_reduce (
	input  logic                       clk,
	input  logic                       en,
	input  logic [tcw_pkg::ANGLE_W-1:0] angle,
	output tcw_pkg::work_t             f,
	output tcw_pkg::tcw_flags_t        flags
);
	import tcw_pkg::*;

	logic [ANGLE_W-1:0] y_s1, y_s2;
	logic               neg_s1, neg_s2, neg_s3;
	logic [N_W-1:0]     n_s2;
	logic [D1_W-1:0]    d1_s3;
	logic [63:0]        m2_s3;
	logic               odd_s3;
	work_t              f_s4;
	tcw_flags_t         flags_s4;

	logic [63:0] prod;
	logic [63:0] c1_sub;
	logic [63:0] d1_full;
	work_t       f_n;

	assign prod    = {32'd0, y_s1} * {32'd0, RECIP_2PI} + N_ROUND;
	assign c1_sub  = ({{(64-N_W){1'b0}}, n_s2} * C1_NUM) << C1_SHIFT;
	assign d1_full = {{(64-ANGLE_W){1'b0}}, y_s2} - c1_sub;
	assign f_n     = (work_t'($signed(d1_s3)) <<< (WORK_FRAC - ANGLE_FRAC_BITS))
		+ $signed(m2_s3);

	// Take magnitude, estimate quadrant count, subtract N*C1, add N*|C2|
	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= angle[ANGLE_W-1];
			y_s1   <= angle[ANGLE_W-1] ? (ANGLE_W'(0) - angle) : angle;
			neg_s2 <= neg_s1;
			y_s2   <= y_s1;
			n_s2   <= prod[63:64-N_W];
			neg_s3 <= neg_s2;
			odd_s3 <= n_s2[0];
			d1_s3  <= d1_full[D1_W-1:0];
			m2_s3  <= {{(64-N_W){1'b0}}, n_s2} * C2Q;
			f_s4          <= f_n;
			flags_s4.neg  <= neg_s3;
			flags_s4.odd  <= odd_s3;
			flags_s4.tiny <= (f_n > -TINY) && (f_n < TINY);
		end
	end

	assign f     = f_s4;
	assign flags = flags_s4;

endmodule

// ===== rtl/tcw_mulq.sv =====
// Pipelined Q.56 multiply with round-half-away and a trailing add.
module tcw_mulq (
	input  logic           clk,
	input  logic           en,
	input  tcw_pkg::work_t a,
	input  tcw_pkg::work_t b,
	input  tcw_pkg::work_t c,
	output tcw_pkg::work_t p
);
	import tcw_pkg::*;

	logic        s_s1, s_s2, s_s3;
	logic [63:0] ma_s1, mb_s1;
	work_t       c_s1, c_s2, c_s3;
	logic [63:0] ll_s2, lh_s2, hl_s2, hh_s2;
	logic [63:0] m_s3;
	work_t       p_s4;

	logic [127:0] sum;

	assign sum = {hh_s2, ll_s2} + {32'd0, lh_s2, 32'd0} + {32'd0, hl_s2, 32'd0}
		+ (128'd1 << (WORK_FRAC - 1));

	// Magnitudes, partial products, rounded sum, sign and add
	always_ff @(posedge clk) begin
		if (en) begin
			s_s1  <= a[63] ^ b[63];
			ma_s1 <= a[63] ? (64'd0 - a) : a;
			mb_s1 <= b[63] ? (64'd0 - b) : b;
			c_s1  <= c;
			s_s2  <= s_s1;
			c_s2  <= c_s1;
			ll_s2 <= ma_s1[31:0]  * mb_s1[31:0];
			lh_s2 <= ma_s1[31:0]  * mb_s1[63:32];
			hl_s2 <= ma_s1[63:32] * mb_s1[31:0];
			hh_s2 <= ma_s1[63:32] * mb_s1[63:32];
			s_s3  <= s_s2;
			c_s3  <= c_s2;
			m_s3  <= sum[WORK_FRAC+63:WORK_FRAC];
			p_s4  <= c_s3 + (s_s3 ? work_t'(64'd0 - m_s3) : work_t'(m_s3));
		end
	end

	assign p = p_s4;

endmodule

// ===== rtl/tcw_div.sv =====
// Quadrant select, radix-2 restoring divider and output saturation.
module tcw_div (
	input  logic                clk,
	input  logic                en,
	input  tcw_pkg::work_t      num,
	input  tcw_pkg::work_t      den,
	input  tcw_pkg::tcw_flags_t flags,
	output tcw_pkg::out_t       res
);
	import tcw_pkg::*;

	logic [63:0] abs_num, abs_den;
	logic        nn_neg, dd_neg, zero;

	logic [63:0] mn_s1, md_s1;
	logic        sg_s1, zero_s1;

	logic [63:0]      rem_s [0:TAN_W-1];
	logic [63:0]      md_s  [0:TAN_W-1];
	logic [TAN_W-1:0] xb_s  [0:TAN_W-1];
	logic [TAN_W-1:0] q_s   [0:TAN_W];
	logic             sg_s  [0:TAN_W];
	logic             ov_s  [0:TAN_W];

	out_t res_s;

	// Swap and negate for odd quadrants
	assign abs_num = num[63] ? (64'd0 - num) : num;
	assign abs_den = den[63] ? (64'd0 - den) : den;
	assign nn_neg  = flags.odd ? ((den != ZERO) && !den[63]) : num[63];
	assign dd_neg  = flags.odd ? num[63] : den[63];
	assign zero    = flags.odd ? (num == ZERO) : (den == ZERO);

	always_ff @(posedge clk) begin
		if (en) begin
			mn_s1   <= flags.odd ? abs_den : abs_num;
			md_s1   <= flags.odd ? abs_num : abs_den;
			sg_s1   <= flags.neg ^ nn_neg ^ dd_neg;
			zero_s1 <= zero;
		end
	end

	// Detect pole or integer part overflow, load the first remainder
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= mn_s1 >> OVF_SHIFT;
			xb_s[0]  <= {mn_s1[OVF_SHIFT-1:0], {(RESULT_FRAC_BITS+1){1'b0}}};
			md_s[0]  <= md_s1;
			q_s[0]   <= '0;
			sg_s[0]  <= sg_s1;
			ov_s[0]  <= zero_s1 || ((mn_s1 >> OVF_SHIFT) >= md_s1);
		end
	end

	// One quotient bit per stage
	for (genvar k = 0; k < TAN_W; k++) begin : g_bit
		logic [64:0] trial;
		logic        take;

		assign trial = {rem_s[k], xb_s[k][TAN_W-1]};
		assign take  = trial >= {1'b0, md_s[k]};

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[k+1]  <= {q_s[k][TAN_W-2:0], take};
				sg_s[k+1] <= sg_s[k];
				ov_s[k+1] <= ov_s[k];
			end
		end

		if (k < TAN_W - 1) begin : g_next
			logic [64:0] diff;
			assign diff = trial - {1'b0, md_s[k]};
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1] <= take ? diff[63:0] : trial[63:0];
					xb_s[k+1]  <= xb_s[k] << 1;
					md_s[k+1]  <= md_s[k];
				end
			end
		end
	end

	// Round, clamp and apply sign
	logic [TAN_W:0]   mag_full;
	logic [TAN_W-1:0] mag, limit, mag_sat;
	logic             ovf;

	assign mag_full = {1'b0, q_s[TAN_W]} + (TAN_W+1)'(1);
	assign mag      = mag_full[TAN_W:1];
	assign limit    = sg_s[TAN_W] ? NEG_LIM : POS_LIM;

	always_comb begin
		if (ov_s[TAN_W]) begin
			mag_sat = limit;
			ovf     = 1'b1;
		end else if (mag > limit) begin
			mag_sat = limit;
			ovf     = 1'b1;
		end else begin
			mag_sat = mag;
			ovf     = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s.tangent  <= sg_s[TAN_W] ? (TAN_W'(0) - mag_sat) : mag_sat;
			res_s.overflow <= ovf;
		end
	end

	assign res = res_s;

endmodule

// ===== rtl/tangent_cody_waite.sv =====
// Top level of the Cody-Waite fixed-point tangent pipeline.
// Usage:
//   Slave stream carries one angle per transfer, Q8.24 two's complement in
//   s_tdata[31:0]. Master stream returns the tangent, Q16.32 two's complement,
//   in m_tdata[47:0] and the overflow flag in m_tuser.
// Pipeline: 4 reduction stages, five chained 4-stage multipliers, 51 divider
//   stages, and the output buffer. The divider resolves one quotient bit per
//   stage.
// Throughput: one angle per clock while the pipeline is not frozen by a stall; every stage advances together.
// Stall: results land in a two-entry output buffer. The pipeline keeps
//   moving, and s_tready stays high, while at most one result waits there;
//   with both entries held and m_tready low, the pipeline freezes in place
//   and s_tready drops until a transfer drains the buffer.
// Reset: arst_n clears all valid bits and the output buffer; no angle is
//   in flight afterwards and the block is ready at once.
`include "tangent_cody_waite_defines.svh"

module tangent_cody_waite (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] angle
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [47:0] tangent
	output logic        m_tuser    // [0] overflow
);
	import tcw_pkg::*;

	logic           en, push, pop, full;
	logic [LAT-1:0] vld_q;
	logic [1:0]     cnt_q;
	out_t           ent0_q, ent1_q;

	work_t      f, g, a1, b1, a2, b2, t, den, num;
	tcw_flags_t flags;
	work_t      g_d_q   [0:7];
	work_t      f_d_q   [0:19];
	work_t      den_d_q [0:3];
	tcw_flags_t fl_d_q  [0:19];
	work_t      num_sel, den_sel;
	out_t       res;
	logic       tan_sat;

	// Advance the whole pipeline while the output buffer has room or m_tready is high
	assign full     = (cnt_q == 2'd2);
	assign en       = !full || m_tready;
	assign s_tready = en;
	assign pop      = m_tvalid && m_tready;
	assign push     = en && vld_q[LAT-1];

	tcw_reduce u_reduce (
		.clk   (clk),
		.en    (en),
		.angle (s_tdata),
		.f     (f),
		.flags (flags)
	);

	// Square, then the two polynomial chains
	tcw_mulq u_g  (.clk(clk), .en(en), .a(f),  .b(f),          .c(ZERO),        .p(g));
	tcw_mulq u_a1 (.clk(clk), .en(en), .a(P3), .b(g),          .c(P2),          .p(a1));
	tcw_mulq u_b1 (.clk(clk), .en(en), .a(Q3), .b(g),          .c(Q2),          .p(b1));
	tcw_mulq u_a2 (.clk(clk), .en(en), .a(a1), .b(g_d_q[3]),   .c(P1),          .p(a2));
	tcw_mulq u_b2 (.clk(clk), .en(en), .a(b1), .b(g_d_q[3]),   .c(Q1),          .p(b2));
	tcw_mulq u_t  (.clk(clk), .en(en), .a(a2), .b(g_d_q[7]),   .c(ZERO),        .p(t));
	tcw_mulq u_dn (.clk(clk), .en(en), .a(b2), .b(g_d_q[7]),   .c(ONE),         .p(den));
	tcw_mulq u_nm (.clk(clk), .en(en), .a(t),  .b(f_d_q[15]),  .c(f_d_q[15]),   .p(num));

	// Delay lines that keep operands aligned with the multiplier chain
	always_ff @(posedge clk) begin
		if (en) begin
			g_d_q[0]   <= g;
			f_d_q[0]   <= f;
			fl_d_q[0]  <= flags;
			den_d_q[0] <= den;
			for (int i = 1; i < 8; i++) g_d_q[i] <= g_d_q[i-1];
			for (int i = 1; i < 20; i++) begin
				f_d_q[i]  <= f_d_q[i-1];
				fl_d_q[i] <= fl_d_q[i-1];
			end
			for (int i = 1; i < 4; i++) den_d_q[i] <= den_d_q[i-1];
		end
	end

	// Bypass the rational form for a tiny reduced angle
	assign num_sel = fl_d_q[19].tiny ? f_d_q[19] : num;
	assign den_sel = fl_d_q[19].tiny ? ONE : den_d_q[3];

	tcw_div u_div (
		.clk   (clk),
		.en    (en),
		.num   (num_sel),
		.den   (den_sel),
		.flags (fl_d_q[19]),
		.res   (res)
	);

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_tvalid};
		end
	end

	// Output buffer occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Output buffer entries; entry 0 is the head
	always_ff @(posedge clk) begin
		if (pop && full) begin
			ent0_q <= ent1_q;
			if (push) ent1_q <= res;
		end else if (push) begin
			if (cnt_q == 2'd0 || pop) ent0_q <= res;
			else ent1_q <= res;
		end
	end

	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata  = ent0_q.tangent;
	assign m_tuser  = ent0_q.overflow;

	// Head tangent sits at one of the two limits
	assign tan_sat = (m_tdata == POS_LIM) || (m_tdata == NEG_LIM);

	`TCW_ASSERT_NEVER(a_buf_bound, cnt_q == 2'd3, "output buffer count out of range")
	`TCW_ASSERT_NEVER(a_buf_overrun, push && full && !pop, "push into full output buffer")
	`TCW_ASSERT(a_stall_hold, !en |=> $stable(vld_q), "pipeline moved during stall")
	`TCW_ASSERT(a_ovf_limit, (m_tvalid && m_tuser) |-> tan_sat, "overflow without saturated tangent")

endmodule
